/* rtl/binary_to_decimal_ascii_top_macros.svh */
// Assertion macros shared by the binary to decimal ASCII modules.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define B2DA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2da assertion failed: same-cycle implication");

// Next-cycle implication, skipped during reset.
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2da assertion failed: next-cycle implication");

`endif

/* rtl/b2da_pkg.sv */
// Types and constants shared by the binary to decimal ASCII modules.
package b2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 6'h39;
  localparam logic [BCD_W-1:0]  BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_W-1:0]  BCD_ADJ_ADD = 4'd3;

  typedef logic [NUM_DIGITS-1:0][BCD_W-1:0] digits_t;

  typedef struct packed {
    digits_t          digits;
    logic [IDX_W-1:0] top_idx;
  } entry_t;

endpackage

/* rtl/b2da_front.sv */
// Front end: accepts a value and converts it to packed BCD by shift and add-3.
`include "binary_to_decimal_ascii_top_macros.svh"

module b2da_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [b2da_pkg::VALUE_W-1:0]      value,
  output logic                              push,
  input  logic                              full,
  output b2da_pkg::entry_t                  push_entry
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  logic [1:0]                         state;
  logic [1:0]                         state_next;
  logic [b2da_pkg::CNT_W-1:0]         cnt;
  logic [b2da_pkg::VALUE_W-1:0]       bin;
  b2da_pkg::digits_t                  digits;
  b2da_pkg::digits_t                  digits_adj;
  logic [b2da_pkg::NUM_DIGITS*b2da_pkg::BCD_W-1:0] adj_bits;
  logic [b2da_pkg::IDX_W-1:0]         top_idx;
  logic                               accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign push     = (state == ST_PUSH) && !full;

  always_comb begin
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (digits[i] >= b2da_pkg::BCD_ADJ_MIN) begin
        digits_adj[i] = digits[i] + b2da_pkg::BCD_ADJ_ADD;
      end else begin
        digits_adj[i] = digits[i];
      end
    end
  end

  assign adj_bits = digits_adj;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (digits[i] != '0) begin
        top_idx = b2da_pkg::IDX_W'(i);
      end
    end
  end

  assign push_entry.digits  = digits;
  assign push_entry.top_idx = top_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (cnt == '1) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_SHIFT) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin    <= value;
      digits <= '0;
    end else if (state == ST_SHIFT) begin
      digits <= {adj_bits[b2da_pkg::NUM_DIGITS*b2da_pkg::BCD_W-2:0],
                 bin[b2da_pkg::VALUE_W-1]};
      bin    <= {bin[b2da_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  `B2DA_ASSERT_NOW(a_front_bin_drained, clk, rst, state == ST_PUSH, bin == '0)
  `B2DA_ASSERT_NEXT(a_front_start, clk, rst, accept, (state == ST_SHIFT) && (cnt == '0))

endmodule

/* rtl/b2da_fifo.sv */
// Short queue of converted BCD entries between the front and back ends.
`include "binary_to_decimal_ascii_top_macros.svh"

module b2da_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b2da_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output b2da_pkg::entry_t pop_entry
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b2da_pkg::entry_t entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  `B2DA_ASSERT_NOW(a_fifo_no_overflow, clk, rst, push, !full)

endmodule

/* rtl/b2da_back.sv */
// Back end: emits the BCD digits of each entry as ASCII, most significant first.
`include "binary_to_decimal_ascii_top_macros.svh"

module b2da_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  b2da_pkg::entry_t              pop_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last_digit
);

  logic                         active;
  logic [b2da_pkg::IDX_W-1:0]   idx;
  b2da_pkg::digits_t            digits;
  logic                         advance;
  logic                         finishing;
  logic                         char_ok;

  assign advance   = !out_valid || !out_stall;
  assign finishing = active && advance && (idx == '0);
  assign pop       = !empty && (!active || finishing);
  assign char_ok   = (digit_char >= b2da_pkg::CHAR_ZERO) &&
                     (digit_char <= b2da_pkg::CHAR_NINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= active;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active) begin
      digit_char <= b2da_pkg::CHAR_ZERO | b2da_pkg::CHAR_W'(digits[idx]);
      last_digit <= (idx == '0);
    end
    if (pop) begin
      digits <= pop_entry.digits;
      idx    <= pop_entry.top_idx;
    end else if (advance && active) begin
      idx    <= idx - 1'b1;
    end
  end

  `B2DA_ASSERT_NOW(a_back_pop_nonempty, clk, rst, pop, !empty)
  `B2DA_ASSERT_NOW(a_back_char_range, clk, rst, out_valid, char_ok)

endmodule

/* rtl/binary_to_decimal_ascii_top.sv */
// Top level of the unsigned 32-bit binary to decimal ASCII converter.
//
//   channel  direction  handshake            fields
//   input    in         in_valid / in_stall  value[31:0]
//   output   out        out_valid / out_stall digit_char[5:0], last_digit
//
// The front end takes one value at a time: an accept, 32 shift and add-3 steps of
// the BCD converter, and entry into the queue, before it takes the next value.
// The back end sends one character per cycle while out_stall is low, 1 to 10 per value.
// The queue of QUEUE_DEPTH entries lets the front convert while the back drains.
// Reset (rst, synchronous) empties the queue and idles both ends.
// A held out_stall freezes the output; in_stall stays high until the entry is queued.
module binary_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2da_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last_digit
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  b2da_pkg::entry_t push_entry;
  b2da_pkg::entry_t pop_entry;

  b2da_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .push       (push),
    .full       (full),
    .push_entry (push_entry)
  );

  b2da_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .pop_entry  (pop_entry)
  );

  b2da_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule
